>>> src/fcca_pkg.sv
// ----------------------------------------------------------------------------
// FAT cluster chain allocator package
// Shared widths, codes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package fcca_pkg;

	localparam int NUM_CLUSTERS = 32;

	localparam int OP_W   = 2;
	localparam int LEN_W  = 6;
	localparam int IDX_W  = 5;
	localparam int LINK_W = 6;
	localparam int CNT_W  = 6;
	localparam int ST_W   = 2;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic signed [LINK_W-1:0] LINK_END   = -6'sd1;
	localparam logic signed [LINK_W-1:0] LINK_NEVER = -6'sd2;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_ZERO_LEN = 2'd2,
		ST_NOT_USED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		K_ALLOC,
		K_ZERO_LEN,
		K_FREE,
		K_FREE_OOR,
		K_READ,
		K_READ_OOR,
		K_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [LEN_W-1:0]  length;
		logic [IDX_W-1:0]  idx;
	} cmd_t;

endpackage

>>> src/fcca_front.sv
// ----------------------------------------------------------------------------
// FAT cluster chain allocator front end
// Accepts request words, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module fcca_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [fcca_pkg::OP_W-1:0]  op,
	input  logic [fcca_pkg::LEN_W-1:0] length,
	input  logic [fcca_pkg::IDX_W-1:0] start_cluster,
	output logic                       cmd_valid,
	input  logic                       cmd_ready,
	output fcca_pkg::cmd_t             cmd
);
	import fcca_pkg::*;

	cmd_t       queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       dec;
	logic       push;
	logic       pop;
	logic       oor;

	always_comb begin
		oor        = 32'(start_cluster) >= NUM_CLUSTERS;
		dec.length = length;
		dec.idx    = start_cluster;
		unique case (op)
			OP_ALLOC: dec.kind = (length == '0) ? K_ZERO_LEN : K_ALLOC;
			OP_FREE:  dec.kind = oor ? K_FREE_OOR : K_FREE;
			OP_READ:  dec.kind = oor ? K_READ_OOR : K_READ;
			default:  dec.kind = K_NOP;
		endcase
	end

	assign in_ready  = count_q != 2'd2;
	assign cmd_valid = count_q != 2'd0;
	assign cmd       = queue_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> src/fcca_back.sv
// ----------------------------------------------------------------------------
// FAT cluster chain allocator back end
// Sequencer over the link table and in-use bitmap, with the result register.
// ----------------------------------------------------------------------------
module fcca_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_ready,
	input  fcca_pkg::cmd_t                     cmd,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [fcca_pkg::ST_W-1:0]          status,
	output logic [fcca_pkg::IDX_W-1:0]         first_cluster,
	output logic signed [fcca_pkg::LINK_W-1:0] link,
	output logic                               in_use,
	output logic [fcca_pkg::CNT_W-1:0]         clusters_freed
);
	import fcca_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC_SCAN,
		S_ALLOC_END,
		S_FREE_STEP,
		S_FREE_NEXT,
		S_READ_WAIT,
		S_REPLY
	} state_t;

	state_t                    state_q;
	logic [NUM_CLUSTERS-1:0]   used_q;
	logic [NUM_CLUSTERS-1:0]   link_ok_q;
	logic [LINK_W-1:0]         link_mem_q [NUM_CLUSTERS];
	logic [LINK_W-1:0]         link_rd_q;
	logic                      link_rd_ok_q;
	logic [CNT_W-1:0]          free_cnt_q;
	logic [IDX_W-1:0]          cur_q;
	logic [IDX_W-1:0]          prev_q;
	logic                      prev_ok_q;
	logic [LEN_W-1:0]          left_q;
	logic [IDX_W-1:0]          first_q;
	logic [CNT_W-1:0]          count_q;
	status_t                   res_status_q;
	logic [IDX_W-1:0]          res_first_q;
	logic signed [LINK_W-1:0]  res_link_q;
	logic                      res_in_use_q;
	logic [CNT_W-1:0]          res_freed_q;
	logic                      out_valid_q;

	logic [IDX_W-1:0]          rd_addr;
	logic                      mem_we;
	logic [IDX_W-1:0]          mem_waddr;
	logic [LINK_W-1:0]         mem_wdata;
	logic                      claim;
	logic signed [LINK_W-1:0]  nxt;
	logic                      walk_stop;
	state_t                    idle_next;
	status_t                   idle_status;

	assign cmd_ready = state_q == S_IDLE;
	assign rd_addr   = (state_q == S_IDLE) ? cmd.idx : cur_q;
	assign claim     = (state_q == S_ALLOC_SCAN) && !used_q[cur_q];
	assign nxt       = link_rd_ok_q ? signed'(link_rd_q) : LINK_NEVER;
	assign walk_stop = nxt[LINK_W-1] || (32'(nxt[IDX_W-1:0]) >= NUM_CLUSTERS) ||
		!used_q[nxt[IDX_W-1:0]] || (count_q == CNT_W'(NUM_CLUSTERS));

	always_comb begin
		idle_status = ST_OK;
		idle_next   = S_REPLY;
		case (cmd.kind)
			K_ALLOC: begin
				if (free_cnt_q < cmd.length) begin
					idle_status = ST_NO_SPACE;
				end else begin
					idle_next = S_ALLOC_SCAN;
				end
			end
			K_ZERO_LEN: idle_status = ST_ZERO_LEN;
			K_FREE: begin
				if (used_q[cmd.idx]) begin
					idle_next = S_FREE_STEP;
				end else begin
					idle_status = ST_NOT_USED;
				end
			end
			K_FREE_OOR: idle_status = ST_NOT_USED;
			K_READ:     idle_next   = S_READ_WAIT;
			K_READ_OOR: idle_status = ST_NOT_USED;
			default:    idle_status = ST_OK;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = prev_q;
		mem_wdata = LINK_END;
		if (claim && prev_ok_q) begin
			mem_we    = 1'b1;
			mem_wdata = LINK_W'(cur_q);
		end else if (state_q == S_ALLOC_END) begin
			mem_we    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem_q[mem_waddr] <= mem_wdata;
		end
		link_rd_q <= link_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_q       <= '0;
			link_ok_q    <= '0;
			link_rd_ok_q <= 1'b0;
			free_cnt_q   <= CNT_W'(NUM_CLUSTERS);
			out_valid_q  <= 1'b0;
		end else begin
			link_rd_ok_q <= link_ok_q[rd_addr];
			if (mem_we) begin
				link_ok_q[mem_waddr] <= 1'b1;
			end
			if (out_valid_q && out_ready && (state_q != S_REPLY)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						res_status_q <= idle_status;
						res_first_q  <= '0;
						res_link_q   <= (cmd.kind == K_READ_OOR) ? LINK_NEVER : '0;
						res_in_use_q <= (cmd.kind == K_READ) && used_q[cmd.idx];
						res_freed_q  <= '0;
						cur_q        <= (cmd.kind == K_FREE) ? cmd.idx : '0;
						prev_ok_q    <= 1'b0;
						left_q       <= cmd.length;
						count_q      <= '0;
						state_q      <= idle_next;
					end
				end
				S_ALLOC_SCAN: begin
					cur_q <= cur_q + 1'b1;
					if (claim) begin
						used_q[cur_q] <= 1'b1;
						free_cnt_q    <= free_cnt_q - 1'b1;
						if (!prev_ok_q) begin
							first_q <= cur_q;
						end
						prev_q    <= cur_q;
						prev_ok_q <= 1'b1;
						left_q    <= left_q - 1'b1;
						if (left_q == LEN_W'(1)) begin
							state_q <= S_ALLOC_END;
						end
					end
				end
				S_ALLOC_END: begin
					res_first_q <= first_q;
					state_q     <= S_REPLY;
				end
				S_FREE_STEP: begin
					used_q[cur_q] <= 1'b0;
					free_cnt_q    <= free_cnt_q + 1'b1;
					count_q       <= count_q + 1'b1;
					state_q       <= S_FREE_NEXT;
				end
				S_FREE_NEXT: begin
					if (walk_stop) begin
						res_freed_q <= count_q;
						state_q     <= S_REPLY;
					end else begin
						cur_q   <= nxt[IDX_W-1:0];
						state_q <= S_FREE_STEP;
					end
				end
				S_READ_WAIT: begin
					res_link_q <= nxt;
					state_q    <= S_REPLY;
				end
				S_REPLY: begin
					if (!out_valid_q || out_ready) begin
						status         <= res_status_q;
						first_cluster  <= res_first_q;
						link           <= res_link_q;
						in_use         <= res_in_use_q;
						clusters_freed <= res_freed_q;
						out_valid_q    <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> src/fat_cluster_chain_allocator.sv
// ----------------------------------------------------------------------------
// FAT cluster chain allocator
// The back end works on one word at a time; the bitmap scan (one cluster per
// cycle) and the chain walk (a free step and a next-link state per link) bound it.
// Reset clears the bitmap and the link valid bits at once: every link reads
// as never used and every cluster is free.
// ----------------------------------------------------------------------------
module fat_cluster_chain_allocator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [fcca_pkg::OP_W-1:0]          op,
	input  logic [fcca_pkg::LEN_W-1:0]         length,
	input  logic [fcca_pkg::IDX_W-1:0]         start_cluster,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [fcca_pkg::ST_W-1:0]          status,
	output logic [fcca_pkg::IDX_W-1:0]         first_cluster,
	output logic signed [fcca_pkg::LINK_W-1:0] link,
	output logic                               in_use,
	output logic [fcca_pkg::CNT_W-1:0]         clusters_freed
);
	import fcca_pkg::*;

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	fcca_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.length        (length),
		.start_cluster (start_cluster),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd)
	);

	fcca_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.cmd            (cmd),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.first_cluster  (first_cluster),
		.link           (link),
		.in_use         (in_use),
		.clusters_freed (clusters_freed)
	);

	// A failed request carries no chain, no count and no in-use flag.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |->
			(first_cluster == '0) && (clusters_freed == '0) && !in_use)
		else $error("failed request returned payload");

	// An in-use flag is only reported by a successful read.
	a_in_use_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_use |-> (status == ST_OK) && (clusters_freed == '0))
		else $error("in-use flag outside a read");

	// A free never releases more clusters than exist and never reports a chain.
	a_freed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (clusters_freed != '0) |->
			(clusters_freed <= CNT_W'(NUM_CLUSTERS)) && (first_cluster == '0) &&
			(link == '0))
		else $error("bad free result");

endmodule

>>> dv/fat_cluster_chain_allocator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FAT cluster chain allocator checker
// Watches both channels of the allocator. Every command word taken at the
// input runs through a local copy of the link table and the in-use bitmap.
// The answer that the copy gives is queued and compared, field by field,
// with the next result word that the block hands over.
// ----------------------------------------------------------------------------
module fat_cluster_chain_allocator_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [fcca_pkg::OP_W-1:0]          op,
	input  logic [fcca_pkg::LEN_W-1:0]         length,
	input  logic [fcca_pkg::IDX_W-1:0]         start_cluster,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [fcca_pkg::ST_W-1:0]          status,
	input  logic [fcca_pkg::IDX_W-1:0]         first_cluster,
	input  logic signed [fcca_pkg::LINK_W-1:0] link,
	input  logic                               in_use,
	input  logic [fcca_pkg::CNT_W-1:0]         clusters_freed,
	output int                                 mismatches,
	output int                                 pending,
	output int                                 words_checked,
	output int                                 chains_granted,
	output int                                 clusters_released,
	output int                                 rejected
);

	import fcca_pkg::*;

	typedef struct packed {
		status_t                   status;
		logic [IDX_W-1:0]          first_cluster;
		logic signed [LINK_W-1:0]  link;
		logic                      in_use;
		logic [CNT_W-1:0]          clusters_freed;
	} answer_t;

	logic signed [LINK_W-1:0] chain_links [NUM_CLUSTERS];
	logic                     cluster_busy [NUM_CLUSTERS];
	answer_t                  answers_due [$];
	answer_t                  wanted;
	answer_t                  seen;
	answer_t                  fresh;

	task automatic run_command(input logic [OP_W-1:0] cmd, input logic [LEN_W-1:0] len,
		input logic [IDX_W-1:0] idx, output answer_t ans);
		int free_cnt;
		int left;
		int prev;
		int cur;
		int count;
		int nxt;
		ans = '0;
		ans.status = ST_OK;
		case (cmd)
			OP_ALLOC: begin
				free_cnt = 0;
				for (int i = 0; i < NUM_CLUSTERS; i++)
					if (!cluster_busy[i])
						free_cnt++;
				if (len == 0) begin
					ans.status = ST_ZERO_LEN;
				end else if (free_cnt < int'(len)) begin
					ans.status = ST_NO_SPACE;
				end else begin
					left = int'(len);
					prev = -1;
					for (int i = 0; i < NUM_CLUSTERS && left > 0; i++) begin
						if (!cluster_busy[i]) begin
							cluster_busy[i] = 1'b1;
							if (prev >= 0)
								chain_links[prev] = LINK_W'(i);
							else
								ans.first_cluster = IDX_W'(i);
							prev = i;
							left--;
						end
					end
					chain_links[prev] = LINK_END;
				end
			end
			OP_FREE: begin
				if (!cluster_busy[idx]) begin
					ans.status = ST_NOT_USED;
				end else begin
					cur = int'(idx);
					count = 0;
					for (int steps = 0; steps < NUM_CLUSTERS; steps++) begin
						cluster_busy[cur] = 1'b0;
						count++;
						nxt = int'(chain_links[cur]);
						if (nxt < 0 || nxt >= NUM_CLUSTERS)
							break;
						if (!cluster_busy[nxt])
							break;
						cur = nxt;
					end
					ans.clusters_freed = (count > 63) ? CNT_W'(63) : CNT_W'(count);
				end
			end
			OP_READ: begin
				ans.link = chain_links[idx];
				ans.in_use = cluster_busy[idx];
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLUSTERS; i++) begin
				chain_links[i] = LINK_NEVER;
				cluster_busy[i] = 1'b0;
			end
			answers_due.delete();
			mismatches = 0;
			pending = 0;
			words_checked = 0;
			chains_granted = 0;
			clusters_released = 0;
			rejected = 0;
		end else begin
			if (out_valid && out_ready) begin
				seen.status = status_t'(status);
				seen.first_cluster = first_cluster;
				seen.link = link;
				seen.in_use = in_use;
				seen.clusters_freed = clusters_freed;
				if (answers_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%t: result word with no command pending: status %0d",
							$realtime, seen.status);
				end else begin
					wanted = answers_due.pop_front();
					words_checked++;
					if (seen.status !== wanted.status
						|| seen.first_cluster !== wanted.first_cluster
						|| seen.link !== wanted.link
						|| seen.in_use !== wanted.in_use
						|| seen.clusters_freed !== wanted.clusters_freed) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%t: word %0d: expected st %0d first %0d link %0d use %0d",
								" freed %0d, got st %0d first %0d link %0d use %0d freed %0d"},
								$realtime, words_checked, wanted.status, wanted.first_cluster,
								wanted.link, wanted.in_use, wanted.clusters_freed,
								seen.status, seen.first_cluster, seen.link, seen.in_use,
								seen.clusters_freed);
					end
				end
			end
			if (in_valid && in_ready) begin
				run_command(op, length, start_cluster, fresh);
				answers_due = {answers_due, fresh};
				if (fresh.status != ST_OK)
					rejected++;
				else if (op == OP_ALLOC)
					chains_granted++;
				else if (op == OP_FREE)
					clusters_released += int'(fresh.clusters_freed);
			end
			pending = answers_due.size();
		end
	end

endmodule

>>> dv/fat_cluster_chain_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FAT cluster chain allocator testbench
// Drives command words into the allocator: a directed opening over empty,
// full and partly freed tables, then a long random mix of allocate, free,
// read and unused commands. The sender works in bursts and the receiver
// stalls on its own pattern, once for a long stretch. The checker beside
// the block predicts every result word and counts the mismatches.
// ----------------------------------------------------------------------------
module fat_cluster_chain_allocator_test;

	import fcca_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_WORDS    = 1026;
	localparam int HOLD_OFF_CYCLES = 500;
	localparam int STALL_LIMIT     = 3000;
	localparam int DRAIN_CYCLES    = 80;

	typedef enum int {
		RX_OPEN,
		RX_BUSY,
		RX_SLUGGISH
	} rx_mode_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [OP_W-1:0]           op = '0;
	logic [LEN_W-1:0]          length = '0;
	logic [IDX_W-1:0]          start_cluster = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [ST_W-1:0]           status;
	logic [IDX_W-1:0]          first_cluster;
	logic signed [LINK_W-1:0]  link;
	logic                      in_use;
	logic [CNT_W-1:0]          clusters_freed;

	int mismatches;
	int pending;
	int words_checked;
	int chains_granted;
	int clusters_released;
	int rejected;
	int words_sent = 0;
	int burst_left = 0;
	int idle_cycles = 0;

	always #2 clk = ~clk;

	fat_cluster_chain_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.length(length),
		.start_cluster(start_cluster),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.first_cluster(first_cluster),
		.link(link),
		.in_use(in_use),
		.clusters_freed(clusters_freed)
	);

	fat_cluster_chain_allocator_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.length(length),
		.start_cluster(start_cluster),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.first_cluster(first_cluster),
		.link(link),
		.in_use(in_use),
		.clusters_freed(clusters_freed),
		.mismatches(mismatches),
		.pending(pending),
		.words_checked(words_checked),
		.chains_granted(chains_granted),
		.clusters_released(clusters_released),
		.rejected(rejected)
	);

	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
	endtask

	task automatic offer_word(input logic [OP_W-1:0] cmd, input int len, input int idx);
		@(negedge clk);
		in_valid <= 1'b1;
		op <= cmd;
		length <= LEN_W'(len);
		start_cluster <= IDX_W'(idx);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
		pace();
	endtask

	initial begin
		rx_mode_t mode;
		int seg;
		bit held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			if (!held && words_sent >= 400) begin
				held = 1'b1;
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
			end else begin
				seg = $urandom_range(8, 60);
				mode = rx_mode_t'($urandom_range(0, 2));
				repeat (seg) begin
					@(negedge clk);
					case (mode)
						RX_OPEN:  out_ready <= 1'b1;
						RX_BUSY:  out_ready <= ($urandom_range(0, 3) != 0);
						default:  out_ready <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
			$display("fat_cluster_chain_allocator_test: done, errors");
			$finish;
		end
	end

	initial begin
		int pick;
		int len;
		int idx;
		logic [OP_W-1:0] cmd;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Fresh table, rejections, a full table, then frees from the head,
		// the middle and through a chain that another allocation reused.
		offer_word(OP_READ, 63, 0);
		offer_word(OP_READ, 0, 31);
		offer_word(OP_ALLOC, 0, 0);
		offer_word(OP_FREE, 5, 5);
		offer_word(OP_ALLOC, 33, 0);
		offer_word(OP_ALLOC, 63, 31);
		offer_word(OP_ALLOC, 32, 0);
		offer_word(OP_READ, 0, 31);
		offer_word(OP_READ, 0, 7);
		offer_word(OP_ALLOC, 1, 0);
		offer_word(OP_FREE, 0, 16);
		offer_word(OP_READ, 0, 16);
		offer_word(OP_FREE, 0, 16);
		offer_word(OP_FREE, 0, 0);
		offer_word(OP_UNUSED, 63, 31);
		offer_word(OP_ALLOC, 3, 0);
		offer_word(OP_ALLOC, 2, 0);
		offer_word(OP_FREE, 0, 1);
		offer_word(OP_ALLOC, 4, 0);
		offer_word(OP_FREE, 0, 0);
		offer_word(OP_FREE, 0, 3);
		offer_word(OP_READ, 0, 6);
		offer_word(OP_ALLOC, 32, 0);
		offer_word(OP_FREE, 0, 0);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(0, 99);
			len = $urandom_range(0, 63);
			idx = $urandom_range(0, 31);
			if (pick < 40) begin
				cmd = OP_ALLOC;
				case ($urandom_range(0, 19))
					0: len = 0;
					1: len = $urandom_range(0, 63);
					2: len = $urandom_range(20, 32);
					default: len = $urandom_range(1, 8);
				endcase
			end else if (pick < 75) begin
				cmd = OP_FREE;
				if ($urandom_range(0, 3) != 0)
					idx = $urandom_range(0, 15);
			end else if (pick < 95) begin
				cmd = OP_READ;
			end else begin
				cmd = OP_UNUSED;
			end
			offer_word(cmd, len, idx);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d command words sent, %0d results checked, %0d mismatches",
			words_sent, words_checked, mismatches);
		$display("%0d chains granted, %0d clusters released, %0d commands refused",
			chains_granted, clusters_released, rejected);
		if (mismatches == 0 && pending == 0)
			$display("fat_cluster_chain_allocator_test: done, clean");
		else
			$display("fat_cluster_chain_allocator_test: done, errors");
		$finish;
	end

endmodule

>>> filelist.f
src/fcca_pkg.sv
src/fcca_front.sv
src/fcca_back.sv
src/fat_cluster_chain_allocator.sv
dv/fat_cluster_chain_allocator_checker.sv
dv/fat_cluster_chain_allocator_test.sv
